// ===== design/channel_packet_decoder_assert.svh =====
// Assertion macros for the checker file of the packet decoder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CHANNEL_PACKET_DECODER_ASSERT_SVH
`define CHANNEL_PACKET_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  // Build limits.
  localparam int MAX_CHANNELS     = 16;
  localparam int MAX_PACKET_BYTES = 64;
  localparam int CFG_DATA_W       = 32;
  localparam logic [7:0] BODY_LIMIT_RESET = 8'd34;

  // Configuration register indexes.
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_CHANNEL_TYPES = 2'd0;
  localparam cfg_addr_t CFG_CHANNEL_COUNT = 2'd1;
  localparam cfg_addr_t CFG_BODY_LIMIT    = 2'd2;

  // Per-channel encoding.
  typedef enum logic [1:0] {
    TYPE_BOOL   = 2'd0,
    TYPE_BYTE   = 2'd1,
    TYPE_WORD   = 2'd2,
    TYPE_BINARY = 2'd3
  } chan_type_t;

  // Closing status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_INVALID    = 3'd2,
    ST_TRUNC      = 3'd3,
    ST_OVER       = 3'd4,
    ST_TRUNC_OVER = 3'd5
  } status_t;

  // Load command from the sequencer to the output register.
  typedef struct packed {
    logic        load;
    logic [4:0]  chan;
    logic [15:0] val;
    logic        has_value;
    logic [2:0]  status;
    logic        last;
  } out_cmd_t;

  // Lowest flagged channel at or above from and below lim; lim if none.
  // Channel i is flagged by bit 15-i of the flag word.
  function automatic logic [4:0] find_flagged(logic [15:0] flag, logic [4:0] from,
                                              logic [4:0] lim);
    logic [4:0] res;
    res = lim;
    for (int i = 15; i >= 0; i--) begin
      if (flag[15 - i] && (5'(i) >= from) && (5'(i) < lim)) begin
        res = 5'(i);
      end
    end
    return res;
  endfunction

  // Two-bit type field of channel idx.
  function automatic chan_type_t chan_type(logic [31:0] types, logic [3:0] idx);
    logic [31:0] sh;
    sh = types >> {idx, 1'b0};
    return chan_type_t'(sh[1:0]);
  endfunction

endpackage

// ===== design/cpd_ram.sv =====
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cpd_ctrl.sv =====
`timescale 1ns / 1ps

module cpd_ctrl import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [31:0] channel_types,
  input  logic [4:0]  chan_limit,
  input  logic [7:0]  body_limit,
  output logic        ram_we,
  output logic [3:0]  ram_waddr,
  output logic [15:0] ram_wdata,
  output logic        ram_re,
  output logic [3:0]  ram_raddr,
  input  logic [15:0] ram_rdata,
  input  logic        out_free,
  output out_cmd_t    out_cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PROC     = 6'b000010,
    S_BOOL     = 6'b000100,
    S_EMIT_RD  = 6'b001000,
    S_EMIT_CAP = 6'b010000,
    S_STATUS   = 6'b100000
  } state_t;

  localparam logic [1:0] BIDX_FLAG_HI = 2'd0;
  localparam logic [1:0] BIDX_FLAG_LO = 2'd1;
  localparam logic [1:0] BIDX_DATA    = 2'd2;
  localparam logic [2:0] BOOL_LAST   = 3'd7;

  state_t      state, state_next;
  logic [15:0] channel_flag, channel_flag_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [4:0]  next_channel, next_channel_next;
  logic [2:0]  bool_pos, bool_pos_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [5:0]  decoded_bytes, decoded_bytes_next;
  logic        error_flag, error_flag_next;
  logic        word_pending, word_pending_next;
  logic [15:0] decoded_mask, decoded_mask_next;
  logic [4:0]  emit_idx, emit_idx_next;
  logic [7:0]  byte_reg, byte_reg_next;
  logic        last_reg, last_reg_next;

  logic [4:0]  search_from;
  logic [4:0]  found;
  chan_type_t  found_type;
  logic        trunc, over;
  logic [8:0]  byte_limit;
  status_t     pkt_status;

  // One shared channel search; the boolean walk looks past the current channel.
  assign search_from = (state == S_BOOL) ? (next_channel + 5'd1) : next_channel;
  assign found       = find_flagged(channel_flag, search_from, chan_limit);
  assign found_type  = chan_type(channel_types, found[3:0]);

  // Closing status of the packet.
  assign byte_limit = (body_limit < 8'(MAX_PACKET_BYTES)) ? {1'b0, body_limit}
                                                          : 9'(MAX_PACKET_BYTES);
  assign trunc = word_pending || (found < chan_limit);
  assign over  = ({3'b000, decoded_bytes} + 9'd2) > byte_limit;

  always_comb begin
    if (channel_flag == 16'h0000) begin
      pkt_status = ST_EMPTY;
    end else if (error_flag) begin
      pkt_status = ST_INVALID;
    end else begin
      case ({trunc, over})
        2'b11:   pkt_status = ST_TRUNC_OVER;
        2'b10:   pkt_status = ST_TRUNC;
        2'b01:   pkt_status = ST_OVER;
        default: pkt_status = ST_OK;
      endcase
    end
  end

  // No byte is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  // Sequencer: header capture, per-byte decode, boolean walk, result scan, status item.
  always_comb begin
    state_next          = state;
    channel_flag_next   = channel_flag;
    byte_index_next     = byte_index;
    next_channel_next   = next_channel;
    bool_pos_next       = bool_pos;
    held_high_byte_next = held_high_byte;
    decoded_bytes_next  = decoded_bytes;
    error_flag_next     = error_flag;
    word_pending_next   = word_pending;
    decoded_mask_next   = decoded_mask;
    emit_idx_next       = emit_idx;
    byte_reg_next       = byte_reg;
    last_reg_next       = last_reg;
    ram_we              = 1'b0;
    ram_waddr           = next_channel[3:0];
    ram_wdata           = 16'h0000;
    ram_re              = 1'b0;
    ram_raddr           = emit_idx[3:0];
    out_cmd             = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          byte_reg_next = byte_value;
          last_reg_next = last_byte;
          case (byte_index)
            BIDX_FLAG_HI: channel_flag_next = {byte_value, 8'h00};
            BIDX_FLAG_LO: channel_flag_next[7:0] = byte_value;
            default: ;
          endcase
          if (byte_index != BIDX_DATA) begin
            byte_index_next = byte_index + 2'd1;
          end
          emit_idx_next = 5'd0;
          if (byte_index == BIDX_DATA) begin
            state_next = S_PROC;
          end else if (last_byte) begin
            state_next = S_EMIT_RD;
          end
        end
      end

      S_PROC: begin
        state_next = last_reg ? S_EMIT_RD : S_IDLE;
        if (error_flag) begin
          // Bytes after an invalid type are dropped.
        end else if (word_pending) begin
          ram_we             = 1'b1;
          ram_waddr          = next_channel[3:0];
          ram_wdata          = {held_high_byte, byte_reg};
          decoded_mask_next  = decoded_mask | (16'h0001 << next_channel[3:0]);
          decoded_bytes_next = decoded_bytes + 6'd2;
          word_pending_next  = 1'b0;
          next_channel_next  = next_channel + 5'd1;
        end else begin
          next_channel_next = found;
          if (found < chan_limit) begin
            case (found_type)
              TYPE_BINARY: error_flag_next = 1'b1;
              TYPE_BYTE: begin
                ram_we             = 1'b1;
                ram_waddr          = found[3:0];
                ram_wdata          = {{8{byte_reg[7]}}, byte_reg};
                decoded_mask_next  = decoded_mask | (16'h0001 << found[3:0]);
                decoded_bytes_next = decoded_bytes + 6'd1;
                next_channel_next  = found + 5'd1;
              end
              TYPE_WORD: begin
                held_high_byte_next = byte_reg;
                word_pending_next   = 1'b1;
              end
              TYPE_BOOL: begin
                decoded_bytes_next = decoded_bytes + 6'd1;
                bool_pos_next      = 3'd0;
                state_next         = S_BOOL;
              end
              default: ;
            endcase
          end
        end
      end

      S_BOOL: begin
        // One boolean bit per cycle, MSB first, into the current channel.
        ram_we            = 1'b1;
        ram_waddr         = next_channel[3:0];
        ram_wdata         = {15'h0000, byte_reg[BOOL_LAST - bool_pos]};
        decoded_mask_next = decoded_mask | (16'h0001 << next_channel[3:0]);
        next_channel_next = next_channel + 5'd1;
        if (bool_pos == BOOL_LAST || found >= chan_limit || found_type != TYPE_BOOL) begin
          bool_pos_next = 3'd0;
          state_next    = last_reg ? S_EMIT_RD : S_IDLE;
        end else begin
          bool_pos_next     = bool_pos + 3'd1;
          next_channel_next = found;
        end
      end

      S_EMIT_RD: begin
        // With a nonzero flag and no invalid type, read each decoded channel's stored value in order.
        if (channel_flag != 16'h0000 && !error_flag && !emit_idx[4]) begin
          if (decoded_mask[emit_idx[3:0]]) begin
            ram_re     = 1'b1;
            state_next = S_EMIT_CAP;
          end else begin
            emit_idx_next = emit_idx + 5'd1;
          end
        end else begin
          state_next = S_STATUS;
        end
      end

      S_EMIT_CAP: begin
        if (out_free) begin
          out_cmd.load      = 1'b1;
          out_cmd.chan      = emit_idx + 5'd1;
          out_cmd.val       = ram_rdata;
          out_cmd.has_value = 1'b1;
          emit_idx_next     = emit_idx + 5'd1;
          state_next        = S_EMIT_RD;
        end
      end

      S_STATUS: begin
        if (out_free) begin
          out_cmd.load        = 1'b1;
          out_cmd.status      = pkt_status;
          out_cmd.last        = 1'b1;
          channel_flag_next   = 16'h0000;
          byte_index_next     = BIDX_FLAG_HI;
          next_channel_next   = 5'd0;
          bool_pos_next       = 3'd0;
          held_high_byte_next = 8'h00;
          decoded_bytes_next  = 6'd0;
          error_flag_next     = 1'b0;
          word_pending_next   = 1'b0;
          decoded_mask_next   = 16'h0000;
          state_next          = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      channel_flag   <= 16'h0000;
      byte_index     <= BIDX_FLAG_HI;
      next_channel   <= 5'd0;
      bool_pos       <= 3'd0;
      held_high_byte <= 8'h00;
      decoded_bytes  <= 6'd0;
      error_flag     <= 1'b0;
      word_pending   <= 1'b0;
      decoded_mask   <= 16'h0000;
      emit_idx       <= 5'd0;
    end else begin
      state          <= state_next;
      channel_flag   <= channel_flag_next;
      byte_index     <= byte_index_next;
      next_channel   <= next_channel_next;
      bool_pos       <= bool_pos_next;
      held_high_byte <= held_high_byte_next;
      decoded_bytes  <= decoded_bytes_next;
      error_flag     <= error_flag_next;
      word_pending   <= word_pending_next;
      decoded_mask   <= decoded_mask_next;
      emit_idx       <= emit_idx_next;
    end
  end

  // Captured input byte.
  always_ff @(posedge clk) begin
    byte_reg <= byte_reg_next;
    last_reg <= last_reg_next;
  end

endmodule

// ===== design/cpd_out.sv =====
`timescale 1ns / 1ps

module cpd_out import cpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  out_cmd_t           out_cmd,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         channel_number,
  output logic signed [15:0] value,
  output logic               has_value,
  output logic [2:0]         status,
  output logic               last_result
);

  // The register may be reloaded in the cycle its transaction completes.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_cmd.load) begin
      channel_number <= out_cmd.chan;
      value          <= out_cmd.val;
      has_value      <= out_cmd.has_value;
      status         <= out_cmd.status;
      last_result    <= out_cmd.last;
    end
  end

endmodule

// ===== design/channel_packet_decoder.sv =====
// A flag byte is taken in the idle state; a data byte holds the input while it is decoded,
// a byte of up to 8 packed booleans while they are walked, one store write per boolean.
// With a nonzero flag and no invalid type the result scan then walks all 16 entries,
// reading the stored value of each decoded channel, then closes the scan and issues the status.
// Otherwise the scan is skipped and the status follows the last processed byte.
// Reset (rst, synchronous): clears packet state and configuration, not the value store.
`timescale 1ns / 1ps

module channel_packet_decoder import cpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  cfg_addr_t             cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            byte_value,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            channel_number,
  output logic signed [15:0]    value,
  output logic                  has_value,
  output logic [2:0]            status,
  output logic                  last_result
);

  logic [31:0] channel_types;
  logic [4:0]  channel_count;
  logic [7:0]  body_limit;
  logic [4:0]  chan_limit;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [15:0] ram_wdata;
  logic        ram_re;
  logic [3:0]  ram_raddr;
  logic [15:0] ram_rdata;
  logic        out_free;
  out_cmd_t    out_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_types <= 32'h0000_0000;
      channel_count <= 5'd0;
      body_limit    <= BODY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHANNEL_TYPES: channel_types <= cfg_data[31:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_BODY_LIMIT:    body_limit    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A count above the channel capacity saturates.
  assign chan_limit = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;

  cpd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CHANNELS)
  ) u_value_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_value    (byte_value),
    .last_byte     (last_byte),
    .channel_types (channel_types),
    .chan_limit    (chan_limit),
    .body_limit    (body_limit),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_free      (out_free),
    .out_cmd       (out_cmd)
  );

  cpd_out u_out (
    .clk            (clk),
    .rst            (rst),
    .out_cmd        (out_cmd),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel_number (channel_number),
    .value          (value),
    .has_value      (has_value),
    .status         (status),
    .last_result    (last_result)
  );

endmodule

// ===== design/cpd_checker.sv =====
`timescale 1ns / 1ps
`include "channel_packet_decoder_assert.svh"

module cpd_checker import cpd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                last_byte,
  input logic                out_valid,
  input logic                out_ready,
  input logic [4:0]          channel_number,
  input logic signed [15:0]  value,
  input logic                has_value,
  input logic [2:0]          status,
  input logic                last_result
);

  // A stalled result transaction keeps its payload.
  `CPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(channel_number) && $stable(status) && $stable(has_value) && $stable(last_result), "result changed while stalled")

  // Value items name a real channel and carry no status.
  `CPD_ASSERT_NOW(a_value_item, out_valid && has_value, channel_number != 5'd0 && channel_number <= 5'(MAX_CHANNELS) && status == ST_OK && !last_result, "malformed value item")

  // The status item closes the packet and carries a defined code.
  `CPD_ASSERT_NOW(a_status_item, out_valid && !has_value, last_result && channel_number == 5'd0 && value == 16'sd0 && status <= ST_TRUNC_OVER, "malformed status item")

  // No byte of the next packet is taken right after a closing byte.
  `CPD_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_byte, !in_ready, "input taken right after last byte")

endmodule

bind channel_packet_decoder cpd_checker u_cpd_checker (.*);
